[design/hbd_pkg.sv]
// Package for the chunked body decoder: phase encoding, character codes,
// the per-byte state and result records, and the hex digit decoder.
// No dependencies.
package hbd_pkg;

  localparam int COUNT_WIDTH = 64;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_A = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [3:0] HEX_TEN = 4'd10;

  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_DATA    = 7'b0000010,
    PH_DCR     = 7'b0000100,
    PH_DLF     = 7'b0001000,
    PH_TRAILER = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [COUNT_WIDTH-1:0] count;
    logic                   digits_seen;
    logic                   digits_ended;
    logic                   pending_cr;
    logic                   line_is_empty;
  } state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic       chunk_end;
    logic       consumed;
    logic       message_done;
    logic       error_flag;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.ok    = 1'b1;
      h.value = 4'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF_A) begin
      h.ok    = 1'b1;
      h.value = 4'(c - CH_LA) + HEX_TEN;
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.ok    = 1'b1;
      h.value = 4'(c - CH_UA) + HEX_TEN;
    end
    return h;
  endfunction

endpackage

[design/http_chunked_body_decoder_unit.sv]
// Top level of the HTTP/1.1 chunked body decoder: input register, decode
// step and result register with valid/ready on both sides.
// Depends on hbd_pkg and hbd_step.

// The decoder takes one word per clock, each word a single byte of a chunked
// message body, and gives exactly one result word per byte: the byte itself
// flagged as payload when it is chunk data, a chunk_end mark on the last data
// byte of each chunk, a consumed flag, and the sticky message_done and
// error_flag indications. A byte is registered on acceptance and its result
// moves into the result register once that register is free; sustained
// throughput is one byte per clock while the result side takes every word.
// That rate is set by the decoder state (phase, 64-bit size count and line
// flags), read and rewritten for every byte; the size accumulation is a
// 4-bit shift and the data count a decrement. When the result side stalls,
// the input register still takes one more byte, and then byte_ready drops
// until result_ready returns. Once done or error is reached the block keeps
// returning results with consumed low until reset.
module http_chunked_body_decoder_unit
  import hbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_in,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] payload_byte,
  output logic       is_payload,
  output logic       chunk_end,
  output logic       consumed,
  output logic       message_done,
  output logic       error_flag
);

  // Input stage.
  logic       in_full;
  logic [7:0] in_byte;

  // Decoder state and result register.
  state_t  state;
  state_t  state_next;
  result_t result;
  result_t result_reg;

  logic advance;
  logic in_take;

  // The held byte moves into the result register when that register is
  // empty or is being emptied in the same cycle.
  assign advance    = in_full && (!result_valid || result_ready);
  assign byte_ready = !in_full || !result_valid || result_ready;
  assign in_take    = byte_valid && byte_ready;

  hbd_step u_step (
    .state      (state),
    .byte_in    (in_byte),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full             <= 1'b0;
      result_valid        <= 1'b0;
      state.phase         <= PH_SIZE;
      state.count         <= '0;
      state.digits_seen   <= 1'b0;
      state.digits_ended  <= 1'b0;
      state.pending_cr    <= 1'b0;
      state.line_is_empty <= 1'b1;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= byte_in;
    end
    if (advance) begin
      result_reg <= result;
    end
  end

  assign payload_byte = result_reg.payload_byte;
  assign is_payload   = result_reg.is_payload;
  assign chunk_end    = result_reg.chunk_end;
  assign consumed     = result_reg.consumed;
  assign message_done = result_reg.message_done;
  assign error_flag   = result_reg.error_flag;

  // A chunk can only end on a data byte, and data bytes always belong to
  // the message.
  a_chunk_end_is_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && chunk_end |-> is_payload && consumed)
    else $error("chunk_end without payload");

  // Done and error exclude each other.
  a_done_error_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(message_done && error_flag))
    else $error("message_done and error_flag together");

  // The error phase is terminal until reset.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_ERROR |=> state.phase == PH_ERROR)
    else $error("left the error phase");

  // The done phase is terminal until reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_DONE |=> state.phase == PH_DONE)
    else $error("left the done phase");

  // Input back-pressure only when both stages hold a word and the result
  // side stalls.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> in_full && result_valid && !result_ready)
    else $error("byte_ready low without a full pipeline");

endmodule

[design/hbd_step.sv]
// Per-byte decode step: from the current state and one body byte, forms the
// next state and the result word. Purely combinational; uses hbd_pkg.
module hbd_step
  import hbd_pkg::*;
(
  input  state_t     state,
  input  logic [7:0] byte_in,
  output state_t     state_next,
  output result_t    result
);

  logic fresh;
  logic is_blank;
  logic count_top;
  hex_t hex;
  logic [COUNT_WIDTH-1:0] count_dec;

  always_comb begin
    fresh     = !state.digits_seen && !state.digits_ended;
    is_blank  = (byte_in == CH_SP) || (byte_in == CH_TAB) ||
                (byte_in == CH_CR) || (byte_in == CH_LF);
    count_top = |state.count[COUNT_WIDTH-1:COUNT_WIDTH-4];
    hex       = hex_decode(byte_in);
    count_dec = state.count - COUNT_WIDTH'(1);

    state_next          = state;
    result.payload_byte = 8'd0;
    result.is_payload   = 1'b0;
    result.chunk_end    = 1'b0;
    result.consumed     = 1'b1;

    unique case (state.phase)
      PH_SIZE: begin
        if (fresh && is_blank) begin
          state_next = state;
        end else if (byte_in == CH_LF && state.pending_cr) begin
          if (!state.digits_seen) begin
            state_next.phase = PH_ERROR;
            result.consumed  = 1'b0;
          end else if (state.count == '0) begin
            state_next.phase         = PH_TRAILER;
            state_next.pending_cr    = 1'b0;
            state_next.line_is_empty = 1'b1;
          end else begin
            state_next.phase      = PH_DATA;
            state_next.pending_cr = 1'b0;
          end
        end else if (byte_in == CH_CR) begin
          state_next.digits_ended = 1'b1;
          state_next.pending_cr   = 1'b1;
        end else begin
          state_next.pending_cr = 1'b0;
          if (hex.ok && !state.digits_ended) begin
            // Saturate once another digit would push bits off the top.
            if (count_top) begin
              state_next.count = '1;
            end else begin
              state_next.count = {state.count[COUNT_WIDTH-5:0], hex.value};
            end
            state_next.digits_seen = 1'b1;
          end else if (byte_in != CH_LF) begin
            state_next.digits_ended = 1'b1;
          end
        end
      end
      PH_DATA: begin
        result.payload_byte = byte_in;
        result.is_payload   = 1'b1;
        state_next.count    = count_dec;
        if (count_dec == '0) begin
          result.chunk_end = 1'b1;
          state_next.phase = PH_DCR;
        end
      end
      PH_DCR: begin
        if (byte_in == CH_CR) begin
          state_next.phase = PH_DLF;
        end else begin
          state_next.phase = PH_ERROR;
          result.consumed  = 1'b0;
        end
      end
      PH_DLF: begin
        if (byte_in == CH_LF) begin
          state_next.phase        = PH_SIZE;
          state_next.count        = '0;
          state_next.digits_seen  = 1'b0;
          state_next.digits_ended = 1'b0;
          state_next.pending_cr   = 1'b0;
        end else begin
          state_next.phase = PH_ERROR;
          result.consumed  = 1'b0;
        end
      end
      PH_TRAILER: begin
        if (byte_in == CH_CR) begin
          if (state.pending_cr) begin
            state_next.line_is_empty = 1'b0;
          end
          state_next.pending_cr = 1'b1;
        end else if (byte_in == CH_LF && state.pending_cr) begin
          if (state.line_is_empty) begin
            state_next.phase = PH_DONE;
          end else begin
            state_next.line_is_empty = 1'b1;
          end
          state_next.pending_cr = 1'b0;
        end else begin
          state_next.line_is_empty = 1'b0;
          state_next.pending_cr    = 1'b0;
        end
      end
      default: begin
        // Done and error both hold; nothing more belongs to the message.
        result.consumed = 1'b0;
      end
    endcase

    result.message_done = (state_next.phase == PH_DONE);
    result.error_flag   = (state_next.phase == PH_ERROR);
  end

endmodule

[tb/chunked_decode_monitor.sv]
`timescale 1ns / 100ps
// Watches both channels of the chunked body decoder and predicts each result word.
// Compares each result word with the prediction and counts the mismatches.
// Depends on hbd_pkg for the phase encoding, the character codes and the result record.
module chunked_decode_monitor
  import hbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  logic [7:0] byte_in,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic [7:0] payload_byte,
  input  logic       is_payload,
  input  logic       chunk_end,
  input  logic       consumed,
  input  logic       message_done,
  input  logic       error_flag,
  output int         fail_count,
  output int         outstanding
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

  phase_t                 body_phase;
  logic [COUNT_WIDTH-1:0] bytes_left;
  logic                   seen_digit;
  logic                   digits_over;
  logic                   cr_held;
  logic                   trailer_line_empty;

  result_t decoded_bytes[$];
  result_t got;
  result_t want;
  int      errors = 0;
  int      word_no = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] result word %0d: %s", $realtime, word_no, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] g, input logic [7:0] w);
    if (g !== w)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, g, w));
  endtask

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
    if (c >= CH_LA && c <= CH_LF_A) return {1'b1, 4'(c - CH_LA + 8'd10)};
    if (c >= CH_UA && c <= CH_UF) return {1'b1, 4'(c - CH_UA + 8'd10)};
    return 5'd0;
  endfunction

  task automatic open_size_line();
    body_phase  = PH_SIZE;
    bytes_left  = '0;
    seen_digit  = 1'b0;
    digits_over = 1'b0;
    cr_held     = 1'b0;
  endtask

  // Advances the predicted decoder state by one body byte and gives its result word.
  task automatic decode_body_byte(input logic [7:0] c, output result_t r);
    logic [4:0] h;
    logic       fresh;
    h = hex_nibble(c);
    fresh = !seen_digit && !digits_over;
    r = '0;
    r.consumed = 1'b1;
    case (body_phase)
      PH_SIZE: begin
        if (fresh && (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
          // Blank before anything else on the size line is skipped.
        end else if (c == CH_LF && cr_held) begin
          if (!seen_digit) begin
            body_phase = PH_ERROR;
            r.consumed = 1'b0;
          end else if (bytes_left == '0) begin
            body_phase = PH_TRAILER;
            cr_held = 1'b0;
            trailer_line_empty = 1'b1;
          end else begin
            body_phase = PH_DATA;
            cr_held = 1'b0;
          end
        end else if (c == CH_CR) begin
          digits_over = 1'b1;
          cr_held = 1'b1;
        end else begin
          cr_held = 1'b0;
          if (h[4] && !digits_over) begin
            if (bytes_left > (COUNT_FULL >> 4))
              bytes_left = COUNT_FULL;
            else
              bytes_left = {bytes_left[COUNT_WIDTH-5:0], h[3:0]};
            seen_digit = 1'b1;
          end else if (c != CH_LF) begin
            digits_over = 1'b1;
          end
        end
      end
      PH_DATA: begin
        r.payload_byte = c;
        r.is_payload = 1'b1;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          r.chunk_end = 1'b1;
          body_phase = PH_DCR;
        end
      end
      PH_DCR: begin
        if (c == CH_CR) begin
          body_phase = PH_DLF;
        end else begin
          body_phase = PH_ERROR;
          r.consumed = 1'b0;
        end
      end
      PH_DLF: begin
        if (c == CH_LF) begin
          open_size_line();
        end else begin
          body_phase = PH_ERROR;
          r.consumed = 1'b0;
        end
      end
      PH_TRAILER: begin
        if (c == CH_CR) begin
          if (cr_held) trailer_line_empty = 1'b0;
          cr_held = 1'b1;
        end else if (c == CH_LF && cr_held) begin
          if (trailer_line_empty) body_phase = PH_DONE;
          else trailer_line_empty = 1'b1;
          cr_held = 1'b0;
        end else begin
          trailer_line_empty = 1'b0;
          cr_held = 1'b0;
        end
      end
      default: begin
        r.consumed = 1'b0;
      end
    endcase
    r.message_done = (body_phase == PH_DONE);
    r.error_flag = (body_phase == PH_ERROR);
  endtask

  // Results are taken before new bytes, so a byte accepted at this edge can never be
  // matched against a word leaving at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      open_size_line();
      trailer_line_empty = 1'b1;
      decoded_bytes.delete();
    end else begin
      if (result_valid && result_ready) begin
        got = {payload_byte, is_payload, chunk_end, consumed, message_done, error_flag};
        if (decoded_bytes.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = decoded_bytes.pop_front();
          check_field("payload_byte", got.payload_byte, want.payload_byte);
          check_field("is_payload", 8'(got.is_payload), 8'(want.is_payload));
          check_field("chunk_end", 8'(got.chunk_end), 8'(want.chunk_end));
          check_field("consumed", 8'(got.consumed), 8'(want.consumed));
          check_field("message_done", 8'(got.message_done), 8'(want.message_done));
          check_field("error_flag", 8'(got.error_flag), 8'(want.error_flag));
        end
        word_no++;
      end
      if (byte_valid && byte_ready) begin
        decode_body_byte(byte_in, want);
        decoded_bytes.insert(decoded_bytes.size(), want);
      end
    end
    fail_count  <= errors;
    outstanding <= decoded_bytes.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top of the chunked body decoder test: clock, reset, body byte stimulus, result side
// back-pressure and the final verdict. Depends on hbd_pkg, chunked_decode_monitor and
// http_chunked_body_decoder_unit.
module testbench
  import hbd_pkg::*;
();

  // The random body is grown chunk by chunk until it reaches this many bytes, and then
  // closed by one of the possible message endings.
  localparam int BODY_TARGET = 1650;
  // Idling stops for this many bytes at the end of the stream.
  localparam int CALM_TAIL   = 150;
  // Bytes after which the result side holds off for a long stretch.
  localparam int HOLD_AT     = 400;
  localparam int LONG_HOLD   = 60;
  // Byte index at which the sender waits until every result word has come back.
  localparam int PAUSE_AT    = 900;
  // The limit covers the slowest correct run, about 2000 bytes with their idles, plus
  // the long hold and the pause, several times over.
  localparam int CYCLE_LIMIT = 200000;

  // The opening bytes: blanks and an empty line ahead of the first size line, a leading
  // zero, a bare LF between digits, an extension holding hex digits and a lone CR, the
  // data extremes 00 and FF, then a one-byte chunk whose data is itself an LF, followed
  // by the CR LF that closes that chunk.
  localparam logic [8*25-1:0] OPENING = {
    CH_SP, CH_TAB, CH_CR, CH_LF,
    CH_ZERO, CH_LF, 8'h32, 8'h3B, CH_LA, 8'h3D, CH_CR, 8'h78, CH_UF, CH_CR, CH_LF,
    8'h00, 8'hFF, CH_CR, CH_LF,
    8'h31, CH_CR, CH_LF, CH_LF, CH_CR, CH_LF
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] byte_in = 8'h00;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] payload_byte;
  logic       is_payload;
  logic       chunk_end;
  logic       consumed;
  logic       message_done;
  logic       error_flag;

  int fail_count;
  int outstanding;

  logic [7:0] body_stream[$];
  int         sent = 0;
  int         calm_from = 0;
  bit         calm = 1'b0;
  bit         holding = 1'b0;
  int         cycles = 0;

  http_chunked_body_decoder_unit u_dut (.*);

  chunked_decode_monitor u_monitor (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // A hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("http_chunked_body_decoder_unit verification failed");
      $finish;
    end
  end

  // Hex digit in a random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v) - 8'd10;
  endfunction

  // Appends one byte to the end of the body.
  task automatic put_byte(input logic [7:0] b);
    body_stream.insert(body_stream.size(), b);
  endtask

  task automatic put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic put_data(input int n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  // Printable text with the odd bare LF, and the odd CR that is followed by something
  // other than LF, so the line stays open.
  task automatic put_text(input int n);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0: begin
          put_byte(CH_CR);
          put_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        1: put_byte(CH_LF);
        default: put_byte(8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end
  endtask

  // Size digits with optional leading zeros; now and then a bare LF falls between two
  // digits, which the size line ignores.
  task automatic put_hex(input logic [63:0] n, input int zeros);
    logic [3:0] nib;
    bit         started;
    started = 1'b0;
    repeat (zeros) put_byte(CH_ZERO);
    for (int i = 15; i >= 0; i--) begin
      nib = n[i*4 +: 4];
      if (nib != 4'd0 || started || i == 0) begin
        if ((started || zeros != 0) && $urandom_range(0, 19) == 0)
          put_byte(CH_LF);
        put_byte(hex_char(nib));
        started = 1'b1;
      end
    end
  endtask

  // A size line: digits, then perhaps an extension or trailing blanks, then CR LF.
  task automatic put_size(input logic [63:0] n);
    put_hex(n, ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        put_byte(8'h3B);
        put_text($urandom_range(0, 6));
      end
      3: repeat ($urandom_range(1, 2)) put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
      default: ;
    endcase
    put_crlf();
  endtask

  // Body construction and the sending side. Most of the stream is well-formed chunks
  // with random sizes, extensions and data; the message then ends in one of five ways
  // (a proper trailer, a size line without digits, a bad byte in place of the data CR or
  // of the data LF, or a size that saturates the count), and a run of bytes that arrive
  // after the end follows, which the block must not consume unless the count saturated.
  initial begin
    int tx_pct;
    int n;
    tx_pct = 20;
    for (int k = 24; k >= 0; k--) put_byte(OPENING[k*8 +: 8]);

    while (body_stream.size() < BODY_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0: put_byte(CH_SP);
            1: put_byte(CH_TAB);
            2: put_byte(CH_CR);
            default: put_byte(CH_LF);
          endcase
        end
      end
      case ($urandom_range(0, 19))
        0: n = $urandom_range(81, 400);
        1, 2, 3, 4, 5: n = $urandom_range(17, 80);
        default: n = $urandom_range(1, 16);
      endcase
      put_size(64'(n));
      put_data(n);
      put_crlf();
    end

    case ($urandom_range(0, 9))
      6: begin
        // A size line that ends without a single hex digit.
        if ($urandom_range(0, 1)) put_byte(CH_SP);
        put_byte(8'h3B);
        put_text($urandom_range(0, 3));
        put_crlf();
      end
      7: begin
        put_size(64'd3);
        put_data(3);
        n = $urandom_range(0, 255);
        while (n == CH_CR) n = $urandom_range(0, 255);
        put_byte(8'(n));
      end
      8: begin
        put_size(64'd2);
        put_data(2);
        put_byte(CH_CR);
        n = $urandom_range(0, 255);
        while (n == CH_LF) n = $urandom_range(0, 255);
        put_byte(8'(n));
      end
      9: begin
        // Seventeen digits overflow the count, which must stick at all ones, so the
        // chunk never ends however much data follows.
        put_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (16) put_byte(hex_char(4'($urandom_range(0, 15))));
        put_crlf();
        put_data(150);
      end
      default: begin
        // Last chunk of size zero, then trailer lines: ordinary fields, a line holding
        // two CRs in a row, and a line holding a bare LF. The empty line closes the
        // message, also when no trailer line comes before it.
        put_size(64'd0);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 2))
            0: begin
              put_byte(CH_CR);
              put_byte(CH_CR);
              put_byte(CH_LF);
            end
            1: begin
              put_byte(CH_LF);
              put_crlf();
            end
            default: begin
              put_text($urandom_range(1, 10));
              put_crlf();
            end
          endcase
        end
        put_crlf();
      end
    endcase
    put_data(30);
    calm_from = body_stream.size() - CALM_TAIL;

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (body_stream[i]) begin
      if ($urandom_range(0, 63) == 0) tx_pct = $urandom_range(0, 2) * 20;
      if (i == PAUSE_AT) begin
        // Let the block drain completely before going on.
        byte_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end else if (!calm && !holding && $urandom_range(1, 100) <= tx_pct) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      if (i == calm_from) calm <= 1'b1;
      byte_valid <= 1'b1;
      byte_in    <= body_stream[i];
      @(posedge clk);
      while (!byte_ready) @(posedge clk);
      sent <= i + 1;
    end
    byte_valid <= 1'b0;

    // One edge first, so that the count of words still owed includes the last byte.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("http_chunked_body_decoder_unit verification clean");
    end else begin
      $display("http_chunked_body_decoder_unit verification failed");
    end
    $finish;
  end

  // Result side: short random stalls whose rate changes now and then, one long hold-off
  // while the sender keeps offering words so that the block fills and stalls its input,
  // and no stalls at all near the end.
  initial begin
    int  rx_pct;
    bit  hold_done;
    rx_pct = 20;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    result_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) rx_pct = $urandom_range(0, 2) * 20;
      if (!hold_done && sent >= HOLD_AT) begin
        hold_done = 1'b1;
        holding      <= 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holding      <= 1'b0;
        result_ready <= 1'b1;
      end else if (!calm && $urandom_range(1, 100) <= rx_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        result_ready <= 1'b1;
      end
    end
  end

endmodule
